// ===== hdl/angle_gyro_kalman_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle/gyro Kalman filter
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ANGLE_GYRO_KALMAN_FILTER_DEFINES_SVH
`define ANGLE_GYRO_KALMAN_FILTER_DEFINES_SVH
`ifndef SYNTH
`define AGK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AGK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AGK_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AGK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/agkf_pkg.sv =====
// ----------------------------------------------------------------------------
// agkf_pkg
// Types, constants and helpers for the angle/gyro Kalman filter.
// ----------------------------------------------------------------------------
package agkf_pkg;

  localparam int FracBitsDefault = 16;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_TIME_STEP   = 2'd3;

  // datapath operations
  localparam logic [4:0] OP_RATE   = 5'd0;
  localparam logic [4:0] OP_ANGP   = 5'd1;
  localparam logic [4:0] OP_PD0    = 5'd2;
  localparam logic [4:0] OP_P00P   = 5'd3;
  localparam logic [4:0] OP_P01P   = 5'd4;
  localparam logic [4:0] OP_P10P   = 5'd5;
  localparam logic [4:0] OP_P11P   = 5'd6;
  localparam logic [4:0] OP_ERR    = 5'd7;
  localparam logic [4:0] OP_E      = 5'd8;
  localparam logic [4:0] OP_DIV0   = 5'd9;
  localparam logic [4:0] OP_DIV1   = 5'd10;
  localparam logic [4:0] OP_C00    = 5'd11;
  localparam logic [4:0] OP_C01    = 5'd12;
  localparam logic [4:0] OP_C10    = 5'd13;
  localparam logic [4:0] OP_C11    = 5'd14;
  localparam logic [4:0] OP_ANGC   = 5'd15;
  localparam logic [4:0] OP_BIASC  = 5'd16;
  localparam logic [4:0] OP_OUT    = 5'd17;
  localparam logic [4:0] OP_LAST   = OP_OUT;

  typedef struct packed {
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] corrected_rate;
    logic signed [31:0] bias_estimate;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== hdl/agkf_div.sv =====
// ----------------------------------------------------------------------------
// agkf_div
// Restoring signed divider: (num << FRAC_BITS) / den, truncated toward zero,
// saturated to 32 bits, zero when den is zero. One quotient bit a cycle.
// ----------------------------------------------------------------------------
module agkf_div #(
  parameter int FRAC_BITS = agkf_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [NW-1:0] dividend;
  logic [NW-1:0] q;
  logic [32:0]   rem;
  logic [31:0]   dmag;
  logic          neg;
  logic          zero;
  logic [33:0]   trial;
  logic [32:0]   shifted;
  logic signed [NW:0] sq;

  assign shifted = {rem[31:0], dividend[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(NW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {(num[31] ? 32'(-num) : num), {FRAC_BITS{1'b0}}};
      dmag     <= den[31] ? 32'(-den) : den;
      neg      <= num[31] ^ den[31];
      zero     <= (den == 32'sd0);
      rem      <= '0;
      q        <= '0;
    end else if (busy) begin
      dividend <= {dividend[NW-2:0], 1'b0};
      if (!trial[33]) begin
        rem <= trial[32:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  assign sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_comb begin
    if (zero) quo = '0;
    else quo = agkf_pkg::sat32(66'(sq));
  end

  `include "angle_gyro_kalman_filter_defines.svh"
  `AGK_ASSERT_NEXT(a_div_done_pulse, clk, rst, done, !done || start)
  `AGK_ASSERT_IMPL(a_div_no_restart, clk, rst, busy, !start)
  `AGK_ASSERT_NEXT(a_div_busy_start, clk, rst, start, busy)
endmodule

// ===== hdl/agkf_datapath.sv =====
// ----------------------------------------------------------------------------
// agkf_datapath
// State, registers and one shared multiply/accumulate unit; divider for gains.
// ----------------------------------------------------------------------------
module agkf_datapath #(
  parameter int FRAC_BITS = agkf_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  input  agkf_pkg::in_item_t   in_item,
  input  agkf_pkg::dp_cmd_t    cmd,
  output agkf_pkg::dp_status_t status,
  output agkf_pkg::out_item_t  out_item
);
  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  logic [23:0] q_ang, q_bias, r_meas;
  logic [15:0] dt;
  logic signed [31:0] angle, bias, p00, p01, p10, p11;
  logic signed [31:0] accel, gyro, rate, pd0, pd1, err, e, k0, k1;
  logic signed [31:0] ma, mb, mc;
  logic               msub;
  logic signed [63:0] prod;
  logic signed [65:0] sh;
  logic signed [31:0] mres;
  logic               div_start, div_done;
  logic signed [31:0] div_num, div_quo;
  logic               div_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ang <= 24'd52;
      q_bias <= 24'd197;
      r_meas <= 24'd32768;
      dt <= 16'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agkf_pkg::REG_ANGLE_NOISE: q_ang <= cfg_data;
        agkf_pkg::REG_BIAS_NOISE:  q_bias <= cfg_data;
        agkf_pkg::REG_MEAS_NOISE:  r_meas <= cfg_data;
        agkf_pkg::REG_TIME_STEP:   dt <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared unit: mc + (or -) round(ma*mb)
  always_comb begin
    ma = '0; mb = '0; mc = '0; msub = 1'b0;
    case (cmd.op)
      agkf_pkg::OP_ANGP: begin ma = rate; mb = {16'd0, dt}; mc = angle; end
      agkf_pkg::OP_P00P: begin ma = pd0; mb = {16'd0, dt}; mc = p00; end
      agkf_pkg::OP_P01P: begin ma = pd1; mb = {16'd0, dt}; mc = p01; end
      agkf_pkg::OP_P10P: begin ma = pd1; mb = {16'd0, dt}; mc = p10; end
      agkf_pkg::OP_P11P: begin ma = {8'd0, q_bias}; mb = {16'd0, dt}; mc = p11; end
      agkf_pkg::OP_C00: begin ma = k0; mb = p00; mc = p00; msub = 1'b1; end
      agkf_pkg::OP_C01: begin ma = k0; mb = pd1; mc = p01; msub = 1'b1; end
      agkf_pkg::OP_C10: begin ma = k1; mb = pd0; mc = p10; msub = 1'b1; end
      agkf_pkg::OP_C11: begin ma = k1; mb = pd1; mc = p11; msub = 1'b1; end
      agkf_pkg::OP_ANGC: begin ma = k0; mb = err; mc = angle; end
      agkf_pkg::OP_BIASC: begin ma = k1; mb = err; mc = bias; end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign sh   = (66'(prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_comb begin
    mres = agkf_pkg::sat32(sh);
    if (msub) mres = agkf_pkg::sat32(66'(mc) - 66'(mres));
    else mres = agkf_pkg::sat32(66'(mc) + 66'(mres));
  end

  // start once per gain; the done cycle must not restart the divider
  assign div_start = cmd.exec && !div_pending &&
    (cmd.op == agkf_pkg::OP_DIV0 || cmd.op == agkf_pkg::OP_DIV1);
  assign div_num = (cmd.op == agkf_pkg::OP_DIV0) ? p00 : p10;

  agkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(e),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) div_pending <= 1'b0;
    else if (div_start) div_pending <= 1'b1;
    else if (div_done) div_pending <= 1'b0;
  end

  always_comb begin
    status.done = 1'b1;
    if (cmd.op == agkf_pkg::OP_DIV0 || cmd.op == agkf_pkg::OP_DIV1)
      status.done = div_done;
  end

  // pd0/pd1 hold t0/t1 (predicted p00/p01) during the correction
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0; bias <= '0;
      p00 <= One; p01 <= '0; p10 <= '0; p11 <= One;
    end else if (cmd.load) begin
      accel <= in_item.accel_angle;
      gyro  <= in_item.gyro_rate;
    end else if (cmd.exec) begin
      case (cmd.op)
        agkf_pkg::OP_RATE: rate <= agkf_pkg::sat32(66'(gyro) - 66'(bias));
        agkf_pkg::OP_ANGP: angle <= mres;
        agkf_pkg::OP_PD0: begin
          pd0 <= agkf_pkg::sat32(66'($signed({1'b0, q_ang})) - 66'(p01) - 66'(p10));
          pd1 <= agkf_pkg::sat32(-66'(p11));
        end
        agkf_pkg::OP_P00P: p00 <= mres;
        agkf_pkg::OP_P01P: p01 <= mres;
        agkf_pkg::OP_P10P: p10 <= mres;
        agkf_pkg::OP_P11P: begin
          p11 <= mres;
          pd0 <= p00;
          pd1 <= p01;
        end
        agkf_pkg::OP_ERR: err <= agkf_pkg::sat32(66'(accel) - 66'(angle));
        agkf_pkg::OP_E: e <= agkf_pkg::sat32(66'($signed({1'b0, r_meas})) + 66'(p00));
        agkf_pkg::OP_DIV0: if (div_done) k0 <= div_quo;
        agkf_pkg::OP_DIV1: if (div_done) k1 <= div_quo;
        agkf_pkg::OP_C00: p00 <= mres;
        agkf_pkg::OP_C01: p01 <= mres;
        agkf_pkg::OP_C10: p10 <= mres;
        agkf_pkg::OP_C11: p11 <= mres;
        agkf_pkg::OP_ANGC: angle <= mres;
        agkf_pkg::OP_BIASC: bias <= mres;
        agkf_pkg::OP_OUT: rate <= agkf_pkg::sat32(66'(gyro) - 66'(bias));
        default: ;
      endcase
    end
  end

  assign out_item.angle_estimate = angle;
  assign out_item.corrected_rate = rate;
  assign out_item.bias_estimate  = bias;

  `include "angle_gyro_kalman_filter_defines.svh"
  `AGK_ASSERT_IMPL(a_dp_div_busy, clk, rst, div_done, div_pending)
  `AGK_ASSERT_IMPL(a_dp_no_restart, clk, rst, div_pending, !div_start)
  `AGK_ASSERT_IMPL(a_dp_load_idle, clk, rst, cmd.load, !cmd.exec)
endmodule

// ===== hdl/agkf_ctrl.sv =====
// ----------------------------------------------------------------------------
// agkf_ctrl
// Sequencer: accept an item, step the datapath through its operations,
// then present the result item.
// ----------------------------------------------------------------------------
module agkf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  agkf_pkg::dp_status_t status,
  output agkf_pkg::dp_cmd_t    cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [4:0] op;
  logic       issued;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.op    = op;
  // division ops issue once then wait for done
  assign cmd.exec  = (state == S_RUN) &&
    !(issued && (op == agkf_pkg::OP_DIV0 || op == agkf_pkg::OP_DIV1)) ||
    (state == S_RUN && issued && status.done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= agkf_pkg::OP_RATE;
      issued <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_RUN;
          op <= agkf_pkg::OP_RATE;
          issued <= 1'b0;
        end
        S_RUN: begin
          if (op == agkf_pkg::OP_DIV0 || op == agkf_pkg::OP_DIV1) begin
            if (!issued) issued <= 1'b1;
            else if (status.done) begin
              issued <= 1'b0;
              op <= op + 5'd1;
            end
          end else if (op == agkf_pkg::OP_LAST) begin
            state <= S_OUT;
          end else begin
            op <= op + 5'd1;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "angle_gyro_kalman_filter_defines.svh"
  `AGK_ASSERT_IMPL(a_ctl_exclusive, clk, rst, 1'b1, !(in_ready && out_valid))
  `AGK_ASSERT_NEXT(a_ctl_start, clk, rst, in_valid && in_ready, state == S_RUN)
  `AGK_ASSERT_NEXT(a_ctl_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

// ===== hdl/angle_gyro_kalman_filter.sv =====
// Time from input accept to result accept is set mostly by two passes of the
//   bit-serial gain divider.
// One item at a time: the next item is accepted once the result is taken.
// Reset: synchronous active-high rst; state zero, covariance identity,
//   registers to their defaults.
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter
// Two-state angle/gyro-bias Kalman filter, Q16.16 saturating arithmetic.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter #(
  parameter int FRAC_BITS = agkf_pkg::FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  agkf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output agkf_pkg::out_item_t out_data
);
  agkf_pkg::dp_cmd_t    cmd;
  agkf_pkg::dp_status_t status;

  agkf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  agkf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .status(status),
    .out_item(out_data)
  );
endmodule

// ===== tb/angle_gyro_kalman_filter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter_checker
// Watches both item channels and the register port. Keeps its own copy of the
// filter state, predicts each result and compares it with the block output.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  agkf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  agkf_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  localparam int FB = 16;

  logic [23:0] q_angle, q_bias, r_meas;
  logic [15:0] dt;
  logic signed [31:0] ang, bia;
  logic signed [31:0] pc [4];
  agkf_pkg::out_item_t est_queue [$];

  function automatic logic signed [31:0] clip(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fmul(input logic signed [65:0] a,
                                              input logic signed [65:0] b);
    logic signed [65:0] p;
    p = a * b + (66'sd1 <<< (FB - 1));
    return clip(p >>> FB);
  endfunction

  function automatic logic signed [31:0] fdiv(input logic signed [31:0] n,
                                              input logic signed [31:0] d);
    logic signed [65:0] num, den;
    if (d == 0) return 0;
    num = 66'(n) <<< FB;
    den = 66'(d);
    return clip(num / den);
  endfunction

  task automatic filter_step(input agkf_pkg::in_item_t x);
    logic signed [65:0] acc, gy, t;
    logic signed [31:0] rate, pd0, pd1, err, e, k0, k1, p00, p01, p10, p11;
    agkf_pkg::out_item_t r;
    acc = 66'(x.accel_angle);
    gy = 66'(x.gyro_rate);
    t = 66'($signed({1'b0, dt}));
    p00 = pc[0]; p01 = pc[1]; p10 = pc[2]; p11 = pc[3];
    rate = clip(gy - bia);
    ang = clip(66'(ang) + fmul(rate, t));
    pd0 = clip(66'($signed({1'b0, q_angle})) - p01 - p10);
    pd1 = clip(-66'(p11));
    p00 = clip(66'(p00) + fmul(pd0, t));
    p01 = clip(66'(p01) + fmul(pd1, t));
    p10 = clip(66'(p10) + fmul(pd1, t));
    p11 = clip(66'(p11) + fmul(66'($signed({1'b0, q_bias})), t));
    err = clip(acc - ang);
    e = clip(66'($signed({1'b0, r_meas})) + p00);
    k0 = fdiv(p00, e);
    k1 = fdiv(p10, e);
    pc[0] = clip(66'(p00) - fmul(k0, p00));
    pc[1] = clip(66'(p01) - fmul(k0, p01));
    pc[2] = clip(66'(p10) - fmul(k1, p00));
    pc[3] = clip(66'(p11) - fmul(k1, p01));
    ang = clip(66'(ang) + fmul(k0, err));
    bia = clip(66'(bia) + fmul(k1, err));
    r.angle_estimate = ang;
    r.corrected_rate = clip(gy - bia);
    r.bias_estimate = bia;
    est_queue.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    agkf_pkg::out_item_t w;
    if (rst) begin
      q_angle <= 24'd52; q_bias <= 24'd197; r_meas <= 24'd32768; dt <= 16'd655;
      ang = 0; bia = 0;
      pc[0] = 32'sd1 <<< FB; pc[1] = 0; pc[2] = 0; pc[3] = 32'sd1 <<< FB;
      est_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          agkf_pkg::REG_ANGLE_NOISE: q_angle <= cfg_data;
          agkf_pkg::REG_BIAS_NOISE:  q_bias <= cfg_data;
          agkf_pkg::REG_MEAS_NOISE:  r_meas <= cfg_data;
          agkf_pkg::REG_TIME_STEP:   dt <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_step(in_data);
      if (out_valid && out_ready) begin
        if (est_queue.size() == 0) begin
          $display("%0t: result with no item outstanding", $realtime);
          fail_count++;
        end else begin
          w = est_queue.pop_front();
          if (out_data.angle_estimate !== w.angle_estimate)
            report_mismatch("angle_estimate", out_data.angle_estimate, w.angle_estimate);
          if (out_data.corrected_rate !== w.corrected_rate)
            report_mismatch("corrected_rate", out_data.corrected_rate, w.corrected_rate);
          if (out_data.bias_estimate !== w.bias_estimate)
            report_mismatch("bias_estimate", out_data.bias_estimate, w.bias_estimate);
        end
      end
    end
    pending = est_queue.size();
  end
endmodule

// ===== tb/angle_gyro_kalman_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_gyro_kalman_filter_tb
// Drives sample pairs in bursts through several register settings, with a
// stalling receiver and one long hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter_tb;
  localparam int LATENCY = 140;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  agkf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  agkf_pkg::out_item_t out_data;
  int fail_count, pending;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit stalls_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  angle_gyro_kalman_filter DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  angle_gyro_kalman_filter_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: own stall pattern, always ready with stalls off, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (!stalls_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_item(input logic [31:0] a, input logic [31:0] g);
    in_data.accel_angle = a;
    in_data.gyro_rate = g;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    in_valid <= 1'b0;
    n = $urandom_range(0, 6) == 0 ? $urandom_range(1, 200) : $urandom_range(0, 3);
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_val(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic random_phase(input int count);
    int burst;
    int mode;
    mode = $urandom_range(0, 3);
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_item(rand_val($urandom_range(0, 5) == 0 ? 0 : mode),
                  rand_val($urandom_range(0, 5) == 0 ? 0 : mode));
        burst--; count--;
      end
      idle_gap();
    end
  endtask

  initial begin
    logic [23:0] settings [6][4];
    settings = '{'{24'd52, 24'd197, 24'd32768, 24'd655},
                 '{24'd0, 24'd0, 24'd0, 24'd0},
                 '{24'hffffff, 24'hffffff, 24'hffffff, 24'h00ffff},
                 '{24'd0, 24'd0, 24'd0, 24'h00ffff},
                 '{24'd300, 24'd1000, 24'd4096, 24'd6554},
                 '{24'hffffff, 24'd1, 24'd0, 24'd1}};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes and sign corners
    send_item(32'h0, 32'h0);
    send_item(32'h7fffffff, 32'h7fffffff);
    send_item(32'h80000000, 32'h80000000);
    send_item(32'h7fffffff, 32'h80000000);
    send_item(32'h80000000, 32'h7fffffff);
    send_item(32'hffffffff, 32'h00000001);
    send_item(32'h00010000, 32'hffff0000);
    send_item(32'h55555555, 32'haaaaaaaa);
    send_item(32'haaaaaaaa, 32'h55555555);
    drain();
    // zero innovation variance: zero measurement noise, zeroed covariance path
    write_reg(agkf_pkg::REG_MEAS_NOISE, 24'd0);
    write_reg(agkf_pkg::REG_ANGLE_NOISE, 24'd0);
    write_reg(agkf_pkg::REG_TIME_STEP, 24'd0);
    write_reg(agkf_pkg::REG_BIAS_NOISE, 24'd0);
    send_item(32'h00020000, 32'h00010000);
    drain();
    write_reg(agkf_pkg::REG_TIME_STEP, 24'hffffff);
    send_item(32'h7fffffff, 32'h7fffffff);
    send_item(32'h80000000, 32'h80000000);
    send_item(32'h12345678, 32'h87654321);
    drain();

    // long receiver hold-off while items keep coming
    hold_off = 1'b1;
    fork
      random_phase(20);
      begin repeat (3000) @(negedge clk); hold_off = 1'b0; end
    join
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(2'(r), settings[ph % 6][r]);
      stalls_on = (ph % 3 != 2);
      random_phase(155);
      drain();
    end

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
